[rtl/core/qsl_pkg.sv]
// Package for the iterative quicksort block.
// Holds the item types, the default capacity and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package qsl_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      final_res;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_POP,
		ST_POPW,
		ST_PIV,
		ST_SCAN,
		ST_SWP1,
		ST_SWP2,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_PUSHR,
		ST_ERD,
		ST_EOUT,
		ST_EWAIT
	} state_t;

endpackage

[rtl/core/qsl_stack.sv]
// Range stack of the quicksort sequencer: a memory of {lo, hi} pairs
// with a push/pop pointer and registered pop data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module qsl_stack #(
	parameter int ENTRY_W = 10,
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               pop,
	input  logic [ENTRY_W-1:0] wdata,
	output logic [ENTRY_W-1:0] rdata,
	output logic               empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [PW-1:0]      ptr_q;
	logic [PW-1:0]      ptr_dec;
	logic [ENTRY_W-1:0] rdata_q;

	assign ptr_dec = ptr_q - PW'(1);
	assign empty   = (ptr_q == '0);
	assign rdata   = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (push) begin
			ptr_q <= ptr_q + PW'(1);
		end else if (pop) begin
			ptr_q <= ptr_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[ptr_q[AW-1:0]] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[ptr_dec[AW-1:0]];
		end
	end

endmodule

[rtl/core/quicksort_lomuto_iterative.sv]
// Iterative quicksort (Lomuto partition). Load: one item per cycle, no result.
// On the item marked last the block stalls its input, sorts in place (per range:
// pop, pivot read, scan, swaps, pivot placement, subrange pushes) through one
// element memory with a read and a write port, then emits each result in turn,
// holding it while stalled. Reset clears the sequencer, the count and the range
// stack; the element memory is not cleared, and no clearing pass runs.
`timescale 1ns / 1ps

module quicksort_lomuto_iterative #(
	parameter int CAPACITY = qsl_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  qsl_pkg::in_item_t  item,
	output logic               res_valid,
	input  logic               res_stall,
	output qsl_pkg::out_item_t res
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IW1 = IW + 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = qsl_pkg::VALUE_W;

	qsl_pkg::state_t state_q, state_d;

	logic signed [VW-1:0] mem [CAPACITY];
	logic signed [VW-1:0] rdata_q;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic signed [VW-1:0] wr_data;

	logic [CW-1:0]        count_q;
	logic [IW-1:0]        lo_q, hi_q, ip_q, j_q, k_q;
	logic signed [VW-1:0] pivot_q, vj_q;
	qsl_pkg::out_item_t   res_q;
	logic                 res_valid_q;

	logic                 stk_push, stk_pop, stk_empty;
	logic [2*IW-1:0]      stk_wdata, stk_rdata;

	logic                 accept;
	logic                 le_pivot;
	logic                 do_swap;
	logic                 more;
	logic                 push_left, push_right;
	logic                 k_is_last;
	logic [CW-1:0]        count_m1;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != qsl_pkg::ST_LOAD);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	assign le_pivot   = (rdata_q <= pivot_q);
	assign do_swap    = le_pivot && (ip_q != j_q);
	assign more       = ((IW1'(j_q) + IW1'(1)) < IW1'(hi_q));
	assign push_left  = (IW1'(ip_q) > (IW1'(lo_q) + IW1'(1)));
	assign push_right = ((IW1'(ip_q) + IW1'(1)) < IW1'(hi_q));
	assign count_m1   = count_q - CW'(1);
	assign k_is_last  = ((CW'(k_q) + CW'(1)) == count_q);

	qsl_stack #(
		.ENTRY_W(2 * IW),
		.DEPTH  (CAPACITY)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (stk_push),
		.pop   (stk_pop),
		.wdata (stk_wdata),
		.rdata (stk_rdata),
		.empty (stk_empty)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			qsl_pkg::ST_LOAD: begin
				if (accept && item.last) state_d = qsl_pkg::ST_START;
			end
			qsl_pkg::ST_START: begin
				state_d = (count_q < CW'(2)) ? qsl_pkg::ST_ERD : qsl_pkg::ST_POP;
			end
			qsl_pkg::ST_POP: begin
				state_d = stk_empty ? qsl_pkg::ST_ERD : qsl_pkg::ST_POPW;
			end
			qsl_pkg::ST_POPW: state_d = qsl_pkg::ST_PIV;
			qsl_pkg::ST_PIV:  state_d = qsl_pkg::ST_SCAN;
			qsl_pkg::ST_SCAN: begin
				if (do_swap) state_d = qsl_pkg::ST_SWP1;
				else if (!more) state_d = qsl_pkg::ST_FIN1;
			end
			qsl_pkg::ST_SWP1: state_d = qsl_pkg::ST_SWP2;
			qsl_pkg::ST_SWP2: state_d = more ? qsl_pkg::ST_SCAN : qsl_pkg::ST_FIN1;
			qsl_pkg::ST_FIN1: state_d = qsl_pkg::ST_FIN2;
			qsl_pkg::ST_FIN2: state_d = qsl_pkg::ST_FIN3;
			qsl_pkg::ST_FIN3: state_d = qsl_pkg::ST_PUSHR;
			qsl_pkg::ST_PUSHR: state_d = qsl_pkg::ST_POP;
			qsl_pkg::ST_ERD:  state_d = qsl_pkg::ST_EOUT;
			qsl_pkg::ST_EOUT: state_d = qsl_pkg::ST_EWAIT;
			qsl_pkg::ST_EWAIT: begin
				if (!res_stall) begin
					state_d = res_q.final_res ? qsl_pkg::ST_LOAD : qsl_pkg::ST_ERD;
				end
			end
			default: state_d = qsl_pkg::ST_LOAD;
		endcase
	end

	// Memory and stack controls
	always_comb begin
		rd_addr   = j_q;
		wr_en     = 1'b0;
		wr_addr   = ip_q;
		wr_data   = pivot_q;
		stk_push  = 1'b0;
		stk_pop   = 1'b0;
		stk_wdata = {lo_q, hi_q};
		case (state_q)
			qsl_pkg::ST_LOAD: begin
				wr_en   = accept && (count_q < CW'(CAPACITY));
				wr_addr = count_q[IW-1:0];
				wr_data = item.value;
			end
			qsl_pkg::ST_START: begin
				stk_push  = (count_q >= CW'(2));
				stk_wdata = {IW'(0), count_m1[IW-1:0]};
			end
			qsl_pkg::ST_POP: begin
				stk_pop = !stk_empty;
			end
			qsl_pkg::ST_POPW: begin
				rd_addr = stk_rdata[IW-1:0];
			end
			qsl_pkg::ST_PIV: begin
				rd_addr = lo_q;
			end
			qsl_pkg::ST_SCAN: begin
				// on a swap fetch the left slot, otherwise prefetch the next element
				rd_addr = do_swap ? ip_q : (j_q + IW'(1));
			end
			qsl_pkg::ST_SWP1: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = rdata_q;
			end
			qsl_pkg::ST_SWP2: begin
				wr_en   = 1'b1;
				wr_addr = ip_q;
				wr_data = vj_q;
				rd_addr = j_q + IW'(1);
			end
			qsl_pkg::ST_FIN1: begin
				rd_addr = ip_q;
			end
			qsl_pkg::ST_FIN2: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = rdata_q;
			end
			qsl_pkg::ST_FIN3: begin
				wr_en     = 1'b1;
				wr_addr   = ip_q;
				wr_data   = pivot_q;
				stk_push  = push_left;
				stk_wdata = {lo_q, ip_q - IW'(1)};
			end
			qsl_pkg::ST_PUSHR: begin
				stk_push  = push_right;
				stk_wdata = {ip_q + IW'(1), hi_q};
			end
			qsl_pkg::ST_ERD: begin
				rd_addr = k_q;
			end
			default: begin
				rd_addr = j_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qsl_pkg::ST_LOAD;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == qsl_pkg::ST_LOAD && accept && count_q < CW'(CAPACITY)) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == qsl_pkg::ST_EOUT) begin
				res_valid_q <= 1'b1;
			end else if (state_q == qsl_pkg::ST_EWAIT && !res_stall) begin
				res_valid_q <= 1'b0;
				if (res_q.final_res) count_q <= '0;
			end
		end
	end

	// Partition and emission datapath
	always_ff @(posedge clk) begin
		case (state_q)
			qsl_pkg::ST_START: begin
				k_q <= '0;
			end
			qsl_pkg::ST_POP: begin
				k_q <= '0;
			end
			qsl_pkg::ST_POPW: begin
				lo_q <= stk_rdata[2*IW-1:IW];
				hi_q <= stk_rdata[IW-1:0];
			end
			qsl_pkg::ST_PIV: begin
				pivot_q <= rdata_q;
				ip_q    <= lo_q;
				j_q     <= lo_q;
			end
			qsl_pkg::ST_SCAN: begin
				if (do_swap) begin
					vj_q <= rdata_q;
				end else begin
					if (le_pivot) ip_q <= ip_q + IW'(1);
					j_q <= j_q + IW'(1);
				end
			end
			qsl_pkg::ST_SWP2: begin
				ip_q <= ip_q + IW'(1);
				j_q  <= j_q + IW'(1);
			end
			qsl_pkg::ST_EOUT: begin
				res_q.sorted_value <= rdata_q;
				res_q.final_res    <= k_is_last;
			end
			qsl_pkg::ST_EWAIT: begin
				if (!res_stall) k_q <= k_q + IW'(1);
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule
